// ===== sv/slgr_pkg.sv =====
// slgr_pkg: widths, register indexes, commands and the pipeline word
// shared by the slant-to-ground range resampler and its square root cells
// no dependencies
package slgr_pkg;

  localparam int LINE_MAX  = 4096;
  localparam int FRAC_BITS = 8;

  localparam int ADDR_W  = $clog2(LINE_MAX);
  localparam int COL_W   = 12;
  localparam int PIX_W   = 24;
  localparam int GRAY_W  = 8;
  localparam int OFS_W   = 24;
  localparam int WIDTH_W = 13;
  localparam int IDX_W   = 3;

  // x = near + column * 2^F, one bit of growth
  localparam int X_W    = OFS_W + 1;
  // radicand x*x + h*h, rounded up to an even width
  localparam int SQ_W   = 2 * X_W + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  // signed difference root + half - slant
  localparam int DIFF_W = ROOT_W + 2;
  localparam int J_W    = ROOT_W + 1 - FRAC_BITS;

  localparam logic [OFS_W-1:0]   HEIGHT_RST = OFS_W'(384000);
  localparam logic [WIDTH_W-1:0] WIDTH_RST  = WIDTH_W'(4096);

  typedef enum logic [IDX_W-1:0] {
    REG_HEIGHT = 3'd0,
    REG_NEAR   = 3'd1,
    REG_SLANT  = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_MODE   = 3'd4
  } slgr_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } slgr_cmd_t;

  // word handed from cell to cell: item tag plus square root state
  typedef struct packed {
    logic              valid;
    slgr_cmd_t         cmd;
    logic [COL_W-1:0]  column;
    logic [PIX_W-1:0]  pixel;
    logic [SQ_W-1:0]   rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } slgr_cell_t;

endpackage

// ===== sv/slgr_ram.sv =====
// slgr_ram: generic simple dual port ram, one write port, one registered read
// no dependencies
module slgr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/slgr_sqrt_cell.sv =====
// slgr_sqrt_cell: one step of the digit-by-digit integer square root
// takes two radicand bits per cycle and passes the item on; uses slgr_pkg
module slgr_sqrt_cell
  import slgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  slgr_cell_t prev,
  output slgr_cell_t cur
);

  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic             fits;
  slgr_cell_t       cur_next;

  always_comb begin
    acc   = {prev.rem, prev.rad[SQ_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W){1'b0}}, prev.root, 2'b01};
    fits  = (acc >= trial);
    cur_next = prev;
    cur_next.rad = prev.rad << 2;
    if (fits) begin
      cur_next.rem  = REM_W'(acc - trial);
      cur_next.root = {prev.root[ROOT_W-2:0], 1'b1};
    end else begin
      cur_next.rem  = acc[REM_W-1:0];
      cur_next.root = {prev.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      cur <= cur_next;
    end
  end

  // remainder never exceeds twice the partial root
  assert property (@(posedge clk) disable iff (rst)
    cur.valid |-> (cur.rem <= {1'b0, cur.root, 1'b0}))
    else $error("sqrt cell remainder out of bound");

endmodule

// ===== sv/slant_to_ground_range_resampler.sv =====
// slant_to_ground_range_resampler: top level, config registers, front end,
// chain of square root cells, line buffer and result stage
// uses slgr_pkg, slgr_sqrt_cell, slgr_ram
//
// usage
//   command channel: an item is taken at a rising edge with start high and
//   busy low. busy stays low, so one item can be taken on every clock.
//   a load item (command 0) writes pixel_in into the line buffer at column
//   and gives no result. a fetch item (command 1) names output column j and
//   gives exactly one result: pixel_out, source_column, out_of_range, shown
//   for one cycle with result_valid high.
//   result channel: result_valid is a one-cycle strobe, the receiver takes
//   the result at the edge that ends that cycle and cannot stall it.
//   a fetch passes stages 0, 1 and 2, the square root cells, p1 and p2 before
//   it is shown. loads travel the same pipeline, so the buffer sees loads and
//   fetches in the order they were taken.
//   throughput: one item per clock, set by the 26-cell square root chain,
//   one radicand bit pair per cell, and the single write/read port pair of
//   the line buffer at the end of the chain.
//   config: wr_en with wr_index/wr_data writes one register at once; the user
//   must write only while no item is in flight; the block does not enforce it.
//   reset: rst is synchronous; it empties the pipeline and loads the register
//   reset values. the line buffer is not cleared.
module slant_to_ground_range_resampler
  import slgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic              command,
  input  logic [COL_W-1:0]  column,
  input  logic [PIX_W-1:0]  pixel_in,
  // config write port
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [OFS_W-1:0]  wr_data,
  // result channel
  output logic              result_valid,
  output logic [PIX_W-1:0]  pixel_out,
  output logic [COL_W-1:0]  source_column,
  output logic              out_of_range
);

  localparam int LATENCY = ROOT_W + 5;

  // config registers
  logic [OFS_W-1:0]   height;
  logic [OFS_W-1:0]   near_ofs;
  logic [OFS_W-1:0]   slant_ofs;
  logic [WIDTH_W-1:0] input_width;
  logic               pixel_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      height      <= HEIGHT_RST;
      near_ofs    <= '0;
      slant_ofs   <= '0;
      input_width <= WIDTH_RST;
      pixel_mode  <= 1'b0;
    end else if (wr_en) begin
      unique case (slgr_reg_t'(wr_index))
        REG_HEIGHT: height      <= wr_data;
        REG_NEAR:   near_ofs    <= wr_data;
        REG_SLANT:  slant_ofs   <= wr_data;
        REG_WIDTH:  input_width <= wr_data[WIDTH_W-1:0];
        REG_MODE:   pixel_mode  <= wr_data[0];
        default: ;
      endcase
    end
  end

  // never held off
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 0: ground position x = near + j * 2^F
  logic             s0_valid;
  slgr_cmd_t        s0_cmd;
  logic [COL_W-1:0] s0_column;
  logic [PIX_W-1:0] s0_pixel;
  logic [X_W-1:0]   s0_x;

  always_ff @(posedge clk) begin
    s0_cmd    <= slgr_cmd_t'(command);
    s0_column <= column;
    s0_pixel  <= pixel_in;
    s0_x      <= {1'b0, near_ofs}
               + {{(X_W-COL_W-FRAC_BITS){1'b0}}, column, {FRAC_BITS{1'b0}}};
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
  end

  // stage 1: squares
  logic               s1_valid;
  slgr_cmd_t          s1_cmd;
  logic [COL_W-1:0]   s1_column;
  logic [PIX_W-1:0]   s1_pixel;
  logic [2*X_W-1:0]   s1_xx;
  logic [2*OFS_W-1:0] s1_hh;

  always_ff @(posedge clk) begin
    s1_cmd    <= s0_cmd;
    s1_column <= s0_column;
    s1_pixel  <= s0_pixel;
    s1_xx     <= s0_x * s0_x;
    s1_hh     <= height * height;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  // stage 2: radicand, enters the cell chain
  slgr_cell_t chain_in;
  slgr_cell_t chain [ROOT_W+1];

  always_ff @(posedge clk) begin
    chain_in.cmd    <= s1_cmd;
    chain_in.column <= s1_column;
    chain_in.pixel  <= s1_pixel;
    chain_in.rad    <= SQ_W'(s1_xx) + SQ_W'(s1_hh);
    chain_in.root   <= '0;
    chain_in.rem    <= '0;
    if (rst) begin
      chain_in.valid <= 1'b0;
    end else begin
      chain_in.valid <= s1_valid;
    end
  end

  assign chain[0] = chain_in;

  // square root: one cell per result bit
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    slgr_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (chain[k]),
      .cur  (chain[k+1])
    );
  end

  slgr_cell_t sq_out;
  assign sq_out = chain[ROOT_W];

  // stage p1: diff = root + half - slant, signed
  logic              p1_valid;
  slgr_cmd_t         p1_cmd;
  logic [COL_W-1:0]  p1_column;
  logic [PIX_W-1:0]  p1_pixel;
  logic [DIFF_W-1:0] p1_diff;

  always_ff @(posedge clk) begin
    p1_cmd    <= sq_out.cmd;
    p1_column <= sq_out.column;
    p1_pixel  <= sq_out.pixel;
    p1_diff   <= {2'b00, sq_out.root}
               + DIFF_W'(1 << (FRAC_BITS - 1))
               - {{(DIFF_W-OFS_W){1'b0}}, slant_ofs};
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= sq_out.valid;
    end
  end

  // source column and range check
  logic           diff_neg;
  logic [J_W-1:0] j_raw;
  logic [J_W-1:0] j_col;
  logic           bad;
  logic [COL_W-1:0] src_sat;

  always_comb begin
    diff_neg = p1_diff[DIFF_W-1];
    j_raw    = p1_diff[DIFF_W-2:FRAC_BITS];
    if (diff_neg) begin
      // strictly within one pixel before the first column rounds to column 0
      j_col = '0;
      bad   = !((&p1_diff[DIFF_W-1:FRAC_BITS]) && (|p1_diff[FRAC_BITS-1:0]));
    end else begin
      j_col = j_raw;
      bad   = 1'b0;
    end
    if (j_col >= {{(J_W-WIDTH_W){1'b0}}, input_width} || (|j_col[J_W-1:ADDR_W])) begin
      bad = 1'b1;
    end
    src_sat = (|j_col[J_W-1:COL_W]) ? {COL_W{1'b1}} : j_col[COL_W-1:0];
  end

  // line buffer: loads write, fetches read, both in taken order
  logic [PIX_W-1:0] buf_rdata;

  slgr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LINE_MAX)
  ) u_line_buf (
    .clk   (clk),
    .we    (p1_valid && p1_cmd == CMD_LOAD),
    .waddr (p1_column[ADDR_W-1:0]),
    .wdata (p1_pixel),
    .raddr (j_col[ADDR_W-1:0]),
    .rdata (buf_rdata)
  );

  // stage p2: result, alongside the registered buffer read
  logic             p2_valid;
  logic             p2_bad;
  logic [COL_W-1:0] p2_src;

  always_ff @(posedge clk) begin
    p2_bad <= bad;
    p2_src <= src_sat;
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid && p1_cmd == CMD_FETCH;
    end
  end

  always_comb begin
    if (p2_bad) begin
      pixel_out = '0;
    end else if (pixel_mode) begin
      pixel_out = buf_rdata;
    end else begin
      pixel_out = {{(PIX_W-GRAY_W){1'b0}}, buf_rdata[GRAY_W-1:0]};
    end
  end

  assign result_valid  = p2_valid;
  assign source_column = p2_src;
  assign out_of_range  = p2_bad;

  // every result comes from an earlier fetch that was taken
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && command == CMD_FETCH, LATENCY))
    else $error("result without matching fetch");

  // an in-range result points inside the valid columns
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !out_of_range) |->
      ({1'b0, source_column} < input_width))
    else $error("in-range source column past input width");

  // gray mode and out of range keep the upper pixel bits clear
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (out_of_range || !pixel_mode)) |->
      (pixel_out[PIX_W-1:GRAY_W] == '0))
    else $error("pixel upper bits set in gray mode or out of range");

endmodule

// ===== sim/slant_to_ground_range_resampler_tb.sv =====
// slant_to_ground_range_resampler_tb: self-checking bench for the slant to ground range
// resampler, with its own line buffer copy and integer square root predictor
// depends on slgr_pkg and slant_to_ground_range_resampler
module slant_to_ground_range_resampler_tb
  import slgr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // fetches and loads ride the same pipe through the block
  localparam int PIPE_SETTLE = 40;
  localparam logic [63:0] ONE_PX     = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ROUND_HALF = 64'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] src;
    logic             oor;
  } range_sample_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic              command;
  logic [COL_W-1:0]  column;
  logic [PIX_W-1:0]  pixel_in;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_index;
  logic [OFS_W-1:0]  wr_data;
  logic              result_valid;
  logic [PIX_W-1:0]  pixel_out;
  logic [COL_W-1:0]  source_column;
  logic              out_of_range;

  // shadow copy of the geometry registers, starting from their reset values
  logic [OFS_W-1:0]   height_q8 = HEIGHT_RST;
  logic [OFS_W-1:0]   near_q8   = '0;
  logic [OFS_W-1:0]   slant_q8  = '0;
  logic [WIDTH_W-1:0] valid_cols = WIDTH_RST;
  logic               rgb_mode  = 1'b0;

  // shadow line buffer; line_loaded marks entries that hold a known pixel
  logic [PIX_W-1:0] line_mem [LINE_MAX];
  bit               line_loaded [LINE_MAX];

  range_sample_t expected_samples[$];

  int items_taken   = 0;
  int results_seen  = 0;
  int errors        = 0;
  int geometry_sets = 0;

  slant_to_ground_range_resampler uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .column        (column),
    .pixel_in      (pixel_in),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .result_valid  (result_valid),
    .pixel_out     (pixel_out),
    .source_column (source_column),
    .out_of_range  (out_of_range)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // bit-serial floor square root, two radicand bits per step
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] trial;
    root = '0;
    rem  = '0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  // ground column j -> slant column J = round((sqrt((near + j*2^F)^2 + h^2) - slant) / 2^F)
  function automatic range_sample_t resample_column(logic [COL_W-1:0] col);
    logic [63:0]   x;
    logic [63:0]   rad;
    logic [63:0]   num;
    logic [63:0]   j;
    logic          miss;
    range_sample_t r;
    x    = 64'(near_q8) + (64'(col) << FRAC_BITS);
    rad  = x * x + 64'(height_q8) * 64'(height_q8);
    num  = int_sqrt(rad) + ROUND_HALF;
    miss = 1'b0;
    j    = '0;
    if (num >= 64'(slant_q8))
      j = (num - 64'(slant_q8)) >> FRAC_BITS;
    else if (64'(slant_q8) - num >= ONE_PX)
      miss = 1'b1;  // source lies before the first pixel
    // truncation toward zero: anything within one pixel below zero reads column 0
    if (j >= 64'(valid_cols) || j >= 64'(LINE_MAX))
      miss = 1'b1;
    r.pixel = '0;
    if (!miss)
      r.pixel = rgb_mode ? line_mem[j[ADDR_W-1:0]]
                         : PIX_W'(line_mem[j[ADDR_W-1:0]][GRAY_W-1:0]);
    r.src = (j > 64'(4095)) ? '1 : j[COL_W-1:0];
    r.oor = miss;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    range_sample_t want;
    if (!rst && result_valid) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual pixel %h column %0d oor %b",
                 $time, pixel_out, source_column, out_of_range);
      end else begin
        want = expected_samples.pop_front();
        results_seen++;
        if (pixel_out !== want.pixel) begin
          errors++;
          $display("%0t: pixel_out mismatch, expected %h actual %h",
                   $time, want.pixel, pixel_out);
        end
        if (source_column !== want.src) begin
          errors++;
          $display("%0t: source_column mismatch, expected %0d actual %0d",
                   $time, want.src, source_column);
        end
        if (out_of_range !== want.oor) begin
          errors++;
          $display("%0t: out_of_range mismatch, expected %b actual %b",
                   $time, want.oor, out_of_range);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one command item; start is left high so a following item goes back to back
  task automatic issue_command(slgr_cmd_t cmd, logic [COL_W-1:0] col,
                               logic [PIX_W-1:0] pix);
    @(negedge clk);
    start    = 1'b1;
    command  = cmd;
    column   = col;
    pixel_in = pix;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_taken++;
    if (cmd == CMD_LOAD) begin
      line_mem[col]    = pix;
      line_loaded[col] = 1'b1;
    end else begin
      expected_samples.push_back(resample_column(col));
    end
  endtask

  // fetch one ground column; a target entry never loaded is filled first
  task automatic fetch_column(logic [COL_W-1:0] col);
    range_sample_t peek;
    peek = resample_column(col);
    if (!peek.oor && !line_loaded[peek.src])
      issue_command(CMD_LOAD, peek.src, PIX_W'($urandom));
    issue_command(CMD_FETCH, col, PIX_W'($urandom));
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk) start = 1'b0;
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender holds off until every outstanding fetch has returned
  task automatic wait_results_drained();
    @(negedge clk) start = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // drained, then long enough for trailing loads to leave the pipe
  task automatic settle();
    wait_results_drained();
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(slgr_reg_t idx, logic [OFS_W-1:0] value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(posedge clk);
    case (idx)
      REG_HEIGHT: height_q8  = value;
      REG_NEAR:   near_q8    = value;
      REG_SLANT:  slant_q8   = value;
      REG_WIDTH:  valid_cols = value[WIDTH_W-1:0];
      REG_MODE:   rgb_mode   = value[0];
      default: ;
    endcase
    @(negedge clk) wr_en = 1'b0;
  endtask

  task automatic apply_geometry(logic [OFS_W-1:0] h, logic [OFS_W-1:0] n,
                                logic [OFS_W-1:0] s, logic [WIDTH_W-1:0] w, logic m);
    settle();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_NEAR, n);
    write_reg(REG_SLANT, s);
    write_reg(REG_WIDTH, OFS_W'(w));
    write_reg(REG_MODE, OFS_W'(m));
    geometry_sets++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers untouched: 1500 px height, no offsets, full width, gray
  task automatic test_reset_values();
    fetch_column('0);
    fetch_column('1);
  endtask

  // with zero height and offsets the mapping is the identity, J == j
  task automatic test_column_extremes();
    apply_geometry('0, '0, '0, 13'd4096, 1'b1);
    issue_command(CMD_LOAD, '0, '0);
    issue_command(CMD_LOAD, '1, '1);
    fetch_column('0);
    fetch_column('1);
    // gray mode keeps only the low byte of the stored pixel
    apply_geometry('0, '0, '0, 13'd4096, 1'b0);
    fetch_column('1);
    issue_command(CMD_LOAD, '0, 24'hA5_5A_C3);
    fetch_column('0);
  endtask

  // slant just above or below the rounded root: truncation toward zero
  task automatic test_rounding_edges();
    logic [63:0] num10;
    num10 = 64'd10 * ONE_PX + ROUND_HALF;
    apply_geometry('0, '0, OFS_W'(num10 + ONE_PX - 1), 13'd4096, 1'b1);
    fetch_column(12'd9);   // more than one full pixel short: before the first pixel
    fetch_column(12'd10);  // just under one pixel short: reads column 0
    fetch_column(12'd11);
    fetch_column(12'd12);
    apply_geometry('0, '0, OFS_W'(num10 + ONE_PX), 13'd4096, 1'b1);
    fetch_column(12'd10);  // exactly one pixel short: before the first pixel
    fetch_column(12'd11);  // exactly zero: column 0
    apply_geometry('0, '0, OFS_W'(ROUND_HALF + 1), 13'd4096, 1'b1);
    fetch_column(12'd10);  // a hair under j rounds down to j-1
  endtask

  task automatic test_width_limits();
    apply_geometry('0, '0, '0, 13'd0, 1'b1);       // zero width: always out of range
    fetch_column('0);
    apply_geometry('0, '0, '0, 13'd1, 1'b0);
    fetch_column(12'd0);
    fetch_column(12'd1);                           // just past the width
    apply_geometry('0, OFS_W'(ONE_PX), '0, 13'd8191, 1'b1);
    fetch_column(12'd4094);                        // last buffer column
    fetch_column(12'd4095);                        // width allows it, buffer does not
    apply_geometry('1, '1, '1, 13'd8191, 1'b1);    // all at max: column saturates
    fetch_column('1);
    apply_geometry('0, '0, '1, 13'd4096, 1'b0);    // slant far beyond any root
    fetch_column('0);
  endtask

  // random geometry phases with random loads and fetches in between
  task automatic test_random_traffic(int phases, int per_phase);
    logic [OFS_W-1:0]   h;
    logic [OFS_W-1:0]   n;
    logic [63:0]        s;
    logic [WIDTH_W-1:0] w;
    bit                 burst;
    for (int p = 0; p < phases; p++) begin
      if (p == 1) begin
        h = '1;
        n = '1;
        s = 64'hFF_FFFF;
      end else if (p == 2) begin
        h = '0;
        n = '0;
        s = '0;
      end else begin
        // magnitudes spread over many octaves, slant near the column 0 distance
        h = OFS_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1));
        n = OFS_W'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1));
        s = int_sqrt(64'(n) * 64'(n) + 64'(h) * 64'(h)) + $urandom_range(0, 1024);
        s = (s < 64'd512) ? 64'd0 : s - 64'd512;
        if (s > 64'hFF_FFFF) s = 64'hFF_FFFF;
      end
      case ($urandom_range(0, 9))
        0:       w = 13'd0;
        1:       w = 13'd8191;
        default: w = WIDTH_W'($urandom_range(1, 4096));
      endcase
      apply_geometry(h, n, OFS_W'(s), w, 1'($urandom_range(0, 1)));
      // some phases run without a single gap
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 99) < 40)
          issue_command(CMD_LOAD, COL_W'($urandom), PIX_W'($urandom));
        else
          fetch_column(COL_W'($urandom));
        if ($urandom_range(0, 199) == 0)
          wait_results_drained();
        else if (!burst)
          idle_cycles(pick_gap());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    command  = CMD_LOAD;
    column   = '0;
    pixel_in = '0;
    wr_en    = 1'b0;
    wr_index = REG_HEIGHT;
    wr_data  = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_column_extremes();
    test_rounding_edges();
    test_width_limits();
    test_random_traffic(8, 125);

    settle();
    $display("run covered %0d items and %0d fetch results under %0d register settings",
             items_taken, results_seen, geometry_sets);
    $display("directed rounding, width and saturation corners, then random geometry");
    if (errors == 0 && expected_samples.size() == 0)
      $display("slant_to_ground_range_resampler_tb: done, clean");
    else
      $display("slant_to_ground_range_resampler_tb: done, errors");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_samples.size());
    $display("slant_to_ground_range_resampler_tb: done, errors");
    $finish;
  end

endmodule
